@@ hdl/jfhs_pkg.sv @@
// ----------------------------------------------------------------------------
// JPEG frame header scanner package
// Phase encoding, status codes and the result record shared by the scanner.
// ----------------------------------------------------------------------------
package jfhs_pkg;

  typedef enum logic [15:0] {
    PH_SIG0    = 16'h0001,
    PH_SIG1    = 16'h0002,
    PH_SIG2    = 16'h0004,
    PH_MARKER  = 16'h0008,
    PH_LEN_HI  = 16'h0010,
    PH_LEN_LO  = 16'h0020,
    PH_SKIP    = 16'h0040,
    PH_PREFIX  = 16'h0080,
    PH_FLEN_HI = 16'h0100,
    PH_FLEN_LO = 16'h0200,
    PH_PREC    = 16'h0400,
    PH_HGT_HI  = 16'h0800,
    PH_HGT_LO  = 16'h1000,
    PH_WID_HI  = 16'h2000,
    PH_WID_LO  = 16'h4000,
    PH_DONE    = 16'h8000
  } jfhs_phase_e;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_SIG   = 3'd1;
  localparam logic [2:0] ST_TRUNC     = 3'd2;
  localparam logic [2:0] ST_NO_PREFIX = 3'd3;
  localparam logic [2:0] ST_SHORT_SOF = 3'd4;
  localparam logic [2:0] ST_LEN_LOW   = 3'd5;

  localparam logic [7:0]  MARKER_PREFIX = 8'hFF;
  localparam logic [7:0]  MARKER_SOI    = 8'hD8;
  localparam logic [7:0]  MARKER_SOF0   = 8'hC0;
  localparam logic [7:0]  SOF_KINDS     = 8'd3;
  localparam logic [15:0] SOF_MIN_LEN   = 16'd5;
  localparam logic [15:0] SEG_MIN_LEN   = 16'd2;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  kind;
    logic [15:0] width;
    logic [15:0] height;
  } jfhs_result_t;

endpackage

@@ hdl/jfhs_parser.sv @@
// ----------------------------------------------------------------------------
// JPEG frame header scanner: byte parser
// Walks the marker segments one byte per cycle while accept_i is high and
// raises at most one result per accepted byte.
// ----------------------------------------------------------------------------
module jfhs_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  end_of_file_i,
  output logic                  res_valid_o,
  output jfhs_pkg::jfhs_result_t res_o
);
  import jfhs_pkg::*;

  jfhs_phase_e phase_q, phase_d;
  logic [15:0] skip_q, skip_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic [1:0]  kind_q, kind_d;
  logic [15:0] height_q, height_d;
  logic [7:0]  width_hi_q, width_hi_d;

  logic [15:0] seg_len;
  logic [7:0]  marker_off;
  logic        hit;

  assign seg_len    = {len_hi_q, data_byte_i};
  assign marker_off = data_byte_i - MARKER_SOF0;

  always_comb begin
    phase_d     = phase_q;
    skip_d      = skip_q;
    len_hi_d    = len_hi_q;
    kind_d      = kind_q;
    height_d    = height_q;
    width_hi_d  = width_hi_q;
    hit         = 1'b0;
    res_o       = '0;
    res_o.status = ST_OK;
    if (accept_i) begin
      case (phase_q)
        PH_SIG0, PH_SIG2: begin
          if (data_byte_i != MARKER_PREFIX) begin
            hit = 1'b1;
            res_o.status = ST_BAD_SIG;
          end else if (phase_q == PH_SIG0) begin
            phase_d = PH_SIG1;
          end else begin
            phase_d = PH_MARKER;
          end
        end
        PH_SIG1: begin
          if (data_byte_i != MARKER_SOI) begin
            hit = 1'b1;
            res_o.status = ST_BAD_SIG;
          end else begin
            phase_d = PH_SIG2;
          end
        end
        PH_MARKER: begin
          if (data_byte_i >= MARKER_SOF0 && marker_off < SOF_KINDS) begin
            kind_d  = marker_off[1:0];
            phase_d = PH_FLEN_HI;
          end else begin
            phase_d = PH_LEN_HI;
          end
        end
        PH_LEN_HI: begin
          len_hi_d = data_byte_i;
          phase_d  = PH_LEN_LO;
        end
        PH_FLEN_HI: begin
          len_hi_d = data_byte_i;
          phase_d  = PH_FLEN_LO;
        end
        PH_LEN_LO: begin
          if (seg_len < SEG_MIN_LEN) begin
            hit = 1'b1;
            res_o.status = ST_LEN_LOW;
          end else begin
            skip_d  = seg_len - SEG_MIN_LEN;
            phase_d = (seg_len != SEG_MIN_LEN) ? PH_SKIP : PH_PREFIX;
          end
        end
        PH_SKIP: begin
          skip_d = skip_q - 16'd1;
          if (skip_q == 16'd1) begin
            phase_d = PH_PREFIX;
          end
        end
        PH_PREFIX: begin
          if (data_byte_i != MARKER_PREFIX) begin
            hit = 1'b1;
            res_o.status = ST_NO_PREFIX;
          end else begin
            phase_d = PH_MARKER;
          end
        end
        PH_FLEN_LO: begin
          skip_d  = seg_len;
          phase_d = PH_PREC;
        end
        PH_PREC: begin
          if (skip_q < SOF_MIN_LEN) begin
            hit = 1'b1;
            res_o.status = ST_SHORT_SOF;
          end else begin
            phase_d = PH_HGT_HI;
          end
        end
        PH_HGT_HI: begin
          height_d = {data_byte_i, 8'h00};
          phase_d  = PH_HGT_LO;
        end
        PH_HGT_LO: begin
          height_d = {height_q[15:8], data_byte_i};
          phase_d  = PH_WID_HI;
        end
        PH_WID_HI: begin
          width_hi_d = data_byte_i;
          phase_d    = PH_WID_LO;
        end
        PH_WID_LO: begin
          hit          = 1'b1;
          res_o.status = ST_OK;
          res_o.kind   = kind_q;
          res_o.width  = {width_hi_q, data_byte_i};
          res_o.height = height_q;
        end
        default: begin
        end
      endcase
      if (hit) begin
        phase_d = PH_DONE;
      end
      if (end_of_file_i) begin
        if (!hit && phase_q != PH_DONE) begin
          hit = 1'b1;
          res_o = '0;
          res_o.status = ST_TRUNC;
        end
        phase_d = PH_SIG0;
      end
    end
  end

  assign res_valid_o = hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SIG0;
      skip_q     <= '0;
      len_hi_q   <= '0;
      kind_q     <= '0;
      height_q   <= '0;
      width_hi_q <= '0;
    end else begin
      phase_q    <= phase_d;
      skip_q     <= skip_d;
      len_hi_q   <= len_hi_d;
      kind_q     <= kind_d;
      height_q   <= height_d;
      width_hi_q <= width_hi_d;
    end
  end

endmodule

@@ hdl/jpeg_frame_header_scanner.sv @@
// A result is written into the registered result queue when the byte that
// decides it is accepted. Throughput: one byte per cycle, set by the single
// parser step per byte and a two-entry result queue that only stalls input
// when both entries wait. Reset clears the parser to the first signature
// byte and empties the result queue.
// ----------------------------------------------------------------------------
// JPEG frame header scanner
// Checks the start signature, skips marker segments and reports the frame
// size from the first SOF0, SOF1 or SOF2 header, one result per file.
// ----------------------------------------------------------------------------
module jpeg_frame_header_scanner (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_file_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [1:0]  frame_kind_o,
  output logic [15:0] image_width_o,
  output logic [15:0] image_height_o
);
  import jfhs_pkg::*;

  logic         accept;
  logic         push;
  logic         pop;
  jfhs_result_t res;
  jfhs_result_t q0_q, q0_d;
  jfhs_result_t q1_q, q1_d;
  logic [1:0]   count_q, count_d;

  assign in_ready_o = (count_q != 2'd2);
  assign accept     = in_valid_i & in_ready_o;

  jfhs_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .data_byte_i   (data_byte_i),
    .end_of_file_i (end_of_file_i),
    .res_valid_o   (push),
    .res_o         (res)
  );

  assign out_valid_o = (count_q != 2'd0);
  assign pop         = out_valid_o & out_ready_i;

  always_comb begin
    q0_d    = q0_q;
    q1_d    = q1_q;
    count_d = count_q;
    if (pop) begin
      q0_d = q1_q;
    end
    if (push) begin
      if (count_q == 2'd0 || (count_q == 2'd1 && pop)) begin
        q0_d = res;
      end else begin
        q1_d = res;
      end
    end
    count_d = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q0_q <= q0_d;
    q1_q <= q1_d;
  end

  assign status_o       = q0_q.status;
  assign frame_kind_o   = q0_q.kind;
  assign image_width_o  = q0_q.width;
  assign image_height_o = q0_q.height;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("result queue count out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (count_q != 2'd2) || pop)
    else $error("result pushed into a full queue");

  a_push_needs_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> accept)
    else $error("result raised without an accepted byte");

  a_ok_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && res.status == ST_OK |-> res.kind != 2'd3)
    else $error("frame kind out of range on a good result");
`endif

endmodule

@@ bench/tb_jpeg_frame_header_scanner.sv @@
// ----------------------------------------------------------------------------
// JPEG frame header scanner testbench
// Streams directed and random JPEG-like files through the scanner with random
// idle and stall patterns and checks every report against a built-in model.
// ----------------------------------------------------------------------------
module tb_jpeg_frame_header_scanner;
  timeunit 1ns;
  timeprecision 1ps;

  import jfhs_pkg::*;

  typedef enum int {
    FAULT_NONE,
    FAULT_SIG,
    FAULT_SEG_LEN,
    FAULT_PREFIX,
    FAULT_SOF_LEN,
    FAULT_CUT
  } file_fault_e;

  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned HOLD_OFF_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        end_of_file = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [1:0]  frame_kind;
  logic [15:0] image_width;
  logic [15:0] image_height;

  jfhs_phase_e  scan_phase = PH_SIG0;
  logic [15:0]  bytes_left = '0;
  logic [7:0]   len_hi = '0;
  logic [1:0]   sof_kind = '0;
  logic [15:0]  hgt = '0;
  logic [7:0]   wid_hi = '0;
  logic         file_done = 1'b0;
  jfhs_result_t expected_reports[$];

  logic [7:0]  file_q[$];
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_cycles = 0;
  int unsigned n_bytes = 0;
  int unsigned n_files = 0;
  int unsigned n_ok = 0;
  int unsigned n_bad = 0;
  int unsigned n_in_stalls = 0;
  int unsigned n_errors = 0;

  jpeg_frame_header_scanner DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .data_byte_i    (data_byte),
    .end_of_file_i  (end_of_file),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (status),
    .frame_kind_o   (frame_kind),
    .image_width_o  (image_width),
    .image_height_o (image_height)
  );

  always #10 clk = ~clk;

  function automatic void post_report(logic [2:0] st, logic [1:0] kd, logic [15:0] w,
                                      logic [15:0] h);
    jfhs_result_t r;
    r.status = st;
    r.kind = kd;
    r.width = w;
    r.height = h;
    expected_reports.push_back(r);
    file_done = 1'b1;
    scan_phase = PH_DONE;
  endfunction

  function automatic void scan_byte(logic [7:0] b, logic eof);
    logic [15:0] seg_len;
    seg_len = {len_hi, b};
    case (scan_phase)
      PH_SIG0: begin
        if (b != MARKER_PREFIX) post_report(ST_BAD_SIG, '0, '0, '0);
        else scan_phase = PH_SIG1;
      end
      PH_SIG1: begin
        if (b != MARKER_SOI) post_report(ST_BAD_SIG, '0, '0, '0);
        else scan_phase = PH_SIG2;
      end
      PH_SIG2: begin
        if (b != MARKER_PREFIX) post_report(ST_BAD_SIG, '0, '0, '0);
        else scan_phase = PH_MARKER;
      end
      PH_MARKER: begin
        if (b >= MARKER_SOF0 && b - MARKER_SOF0 < SOF_KINDS) begin
          sof_kind = 2'(b - MARKER_SOF0);
          scan_phase = PH_FLEN_HI;
        end else begin
          scan_phase = PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        len_hi = b;
        scan_phase = PH_LEN_LO;
      end
      PH_FLEN_HI: begin
        len_hi = b;
        scan_phase = PH_FLEN_LO;
      end
      PH_LEN_LO: begin
        if (seg_len < SEG_MIN_LEN) begin
          post_report(ST_LEN_LOW, '0, '0, '0);
        end else begin
          bytes_left = seg_len - SEG_MIN_LEN;
          scan_phase = (bytes_left != 0) ? PH_SKIP : PH_PREFIX;
        end
      end
      PH_SKIP: begin
        bytes_left = bytes_left - 16'd1;
        if (bytes_left == 0) scan_phase = PH_PREFIX;
      end
      PH_PREFIX: begin
        if (b != MARKER_PREFIX) post_report(ST_NO_PREFIX, '0, '0, '0);
        else scan_phase = PH_MARKER;
      end
      PH_FLEN_LO: begin
        bytes_left = seg_len;
        scan_phase = PH_PREC;
      end
      PH_PREC: begin
        if (bytes_left < SOF_MIN_LEN) post_report(ST_SHORT_SOF, '0, '0, '0);
        else scan_phase = PH_HGT_HI;
      end
      PH_HGT_HI: begin
        hgt = {b, 8'h00};
        scan_phase = PH_HGT_LO;
      end
      PH_HGT_LO: begin
        hgt[7:0] = b;
        scan_phase = PH_WID_HI;
      end
      PH_WID_HI: begin
        wid_hi = b;
        scan_phase = PH_WID_LO;
      end
      PH_WID_LO: begin
        post_report(ST_OK, sof_kind, {wid_hi, b}, hgt);
      end
      default: begin
      end
    endcase
    if (eof) begin
      if (!file_done) post_report(ST_TRUNC, '0, '0, '0);
      scan_phase = PH_SIG0;
      file_done = 1'b0;
    end
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endfunction

  always @(posedge clk) begin : report_check
    jfhs_result_t want;
    if (rst_n) begin
      if (in_valid && !in_ready) n_in_stalls++;
      if (in_valid && in_ready) scan_byte(data_byte, end_of_file);
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          $error("Report with status %0d arrived with nothing expected.", status);
          n_errors++;
        end else begin
          want = expected_reports.pop_front();
          check_field("status", 16'(want.status), 16'(status));
          check_field("frame_kind", 16'(want.kind), 16'(frame_kind));
          check_field("image_width", want.width, image_width);
          check_field("image_height", want.height, image_height);
          if (want.status == ST_OK) n_ok++;
          else n_bad++;
        end
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles != 0) begin
        out_ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    end_of_file <= last;
    do @(posedge clk); while (!in_ready);
    n_bytes++;
  endtask

  task automatic send_file();
    foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1);
    n_files++;
  endtask

  task automatic wait_for_reports();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic void put_sig(int bad_pos);
    logic [7:0] sig[3];
    sig = '{MARKER_PREFIX, MARKER_SOI, MARKER_PREFIX};
    for (int i = 0; i < 3; i++) begin
      if (i == bad_pos) file_q.push_back(sig[i] ^ 8'($urandom_range(1, 255)));
      else file_q.push_back(sig[i]);
    end
  endfunction

  function automatic void make_file();
    file_fault_e fault;
    int unsigned nseg;
    int unsigned bad_seg;
    int unsigned keep;
    logic [7:0]  mk;
    logic [15:0] len;
    file_q.delete();
    if ($urandom_range(99) >= 80) begin
      if ($urandom_range(1) == 1) put_sig(-1);
      repeat ($urandom_range(1, 8)) file_q.push_back(8'($urandom));
      return;
    end
    fault = FAULT_NONE;
    if ($urandom_range(99) < 35) fault = file_fault_e'($urandom_range(FAULT_SIG, FAULT_CUT));
    put_sig(fault == FAULT_SIG ? int'($urandom_range(0, 2)) : -1);
    nseg = $urandom_range((fault == FAULT_SEG_LEN || fault == FAULT_PREFIX) ? 1 : 0, 3);
    bad_seg = (nseg == 0) ? 0 : $urandom_range(0, nseg - 1);
    for (int s = 0; s < nseg; s++) begin
      if ($urandom_range(9) == 0) begin
        mk = MARKER_PREFIX;
      end else begin
        mk = 8'($urandom);
        while (mk >= MARKER_SOF0 && mk - MARKER_SOF0 < SOF_KINDS) mk = 8'($urandom);
      end
      if (fault == FAULT_SEG_LEN && s == bad_seg) len = 16'($urandom_range(0, 1));
      else if ($urandom_range(19) == 0) len = 16'($urandom_range(256, 300));
      else len = 16'($urandom_range(2, 10));
      file_q.push_back(mk);
      file_q.push_back(len[15:8]);
      file_q.push_back(len[7:0]);
      if (len >= SEG_MIN_LEN) repeat (len - SEG_MIN_LEN) file_q.push_back(8'($urandom));
      if (fault == FAULT_PREFIX && s == bad_seg) file_q.push_back(8'($urandom_range(0, 254)));
      else file_q.push_back(MARKER_PREFIX);
    end
    file_q.push_back(MARKER_SOF0 + 8'($urandom_range(0, 2)));
    if (fault == FAULT_SOF_LEN) len = 16'($urandom_range(0, 4));
    else if ($urandom_range(9) == 0) len = 16'($urandom_range(5, 65535));
    else len = 16'($urandom_range(5, 17));
    file_q.push_back(len[15:8]);
    file_q.push_back(len[7:0]);
    repeat (5) file_q.push_back(8'($urandom));
    repeat ($urandom_range(0, 3)) file_q.push_back(8'($urandom));
    if (fault == FAULT_CUT) begin
      keep = $urandom_range(1, file_q.size() - 1);
      while (file_q.size() > keep) void'(file_q.pop_back());
    end
  endfunction

  task automatic test_directed_cases();
    idle_pct = 0;
    stall_pct = 0;
    file_q = '{8'h00};
    send_file();
    file_q = '{MARKER_PREFIX, MARKER_SOI, MARKER_PREFIX, MARKER_SOF0 + 8'd2, 8'h00, 8'h05,
               8'h08, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_file();
    file_q = '{MARKER_PREFIX, MARKER_SOI, MARKER_PREFIX, 8'hE0, 8'h00, 8'h01};
    send_file();
    file_q = '{MARKER_PREFIX, MARKER_SOI, MARKER_PREFIX, MARKER_SOF0, 8'h00, 8'h04, 8'h08};
    send_file();
    file_q = '{MARKER_PREFIX, MARKER_SOI, MARKER_PREFIX, 8'hE1, 8'h00, 8'h02, 8'h00};
    send_file();
    wait_for_reports();
  endtask

  task automatic test_stream(int unsigned sender_idle, int unsigned recv_stall,
                             int unsigned n_target);
    int unsigned first;
    idle_pct = sender_idle;
    stall_pct = recv_stall;
    first = n_bytes;
    while (n_bytes - first < n_target) begin
      make_file();
      send_file();
    end
    wait_for_reports();
  endtask

  task automatic test_result_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    hold_cycles = HOLD_OFF_CYCLES;
    repeat (40) begin
      file_q.delete();
      file_q.push_back(8'($urandom));
      send_file();
    end
    wait_for_reports();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_stream(0, 0, 430);
    test_stream(75, 0, 430);
    test_stream(0, 75, 430);
    test_stream(12, 12, 430);
    test_result_backpressure();
    $display("Scanned %0d bytes in %0d files; %0d frame sizes and %0d error reports checked.",
             n_bytes, n_files, n_ok, n_bad);
    $display("Input was held back by a full result queue for %0d cycles.", n_in_stalls);
    if (n_errors == 0 && expected_reports.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $error("Run did not finish in time; %0d reports still pending.", expected_reports.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ files.f @@
hdl/jfhs_pkg.sv
hdl/jfhs_parser.sv
hdl/jpeg_frame_header_scanner.sv
bench/tb_jpeg_frame_header_scanner.sv
